@@ rtl/nibble_rle_palette_decoder_macros.svh @@
// Assertion macros shared by the sprite decoder RTL.
`ifndef NIBBLE_RLE_PALETTE_DECODER_MACROS_SVH
`define NIBBLE_RLE_PALETTE_DECODER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define NRPD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("decoder assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define NRPD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("decoder assertion failed");

`endif

@@ rtl/nrpd_pkg.sv @@
// Types, constants and palette contents for the run-length sprite decoder.
package nrpd_pkg;

  localparam int MaxSide = 64;
  localparam int PalDepth = 256;
  localparam int PalWidth = 24;

  // Configuration register indexes.
  localparam logic [1:0] CfgImageWidth = 2'd0;
  localparam logic [1:0] CfgImageHeight = 2'd1;
  localparam logic [1:0] CfgGhostMode = 2'd2;

  localparam logic [6:0] WidthReset = 7'd44;
  localparam logic [6:0] HeightReset = 7'd44;
  localparam logic [7:0] AlphaGhost = 8'd127;
  localparam logic [7:0] AlphaOpaque = 8'd255;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_sprite;
  } in_item_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_of_run;
    logic       image_done;
    logic       overrun_error;
  } out_item_t;

  // Palette entries as {blue, green, red}.
  localparam logic [PalWidth-1:0] PaletteRom [PalDepth] = '{
    24'hffffff, 24'hffffcc, 24'hffff99, 24'hffff66, 24'hffff33, 24'hffff00, 24'hffdfff,
    24'hffdfcc, 24'hffdf99, 24'hffdf66, 24'hffdf33, 24'hffdf00, 24'hffbfff, 24'hffbfcc,
    24'hffbf99, 24'hffbf66, 24'hffbf33, 24'hffbf00, 24'hff9fff, 24'hff9fcc, 24'hff9f99,
    24'hff9f66, 24'hff9f33, 24'hff9f00, 24'hff7fff, 24'hff7fcc, 24'hff7f99, 24'hff7f66,
    24'hff7f33, 24'hff7f00, 24'hff5fff, 24'hff5fcc, 24'hff5f99, 24'hff5f66, 24'hff5f33,
    24'hff5f00, 24'hff3fff, 24'hff3fcc, 24'hff3f99, 24'hff3f66, 24'hff3f33, 24'hff3f00,
    24'hff1fff, 24'hff1fcc, 24'hff1f99, 24'hff1f66, 24'hff1f33, 24'hff1f00, 24'hff00ff,
    24'hff00cc, 24'hff0099, 24'hff0066, 24'hff0033, 24'hff0000, 24'heeeeee, 24'hdddddd,
    24'hcccccc, 24'hbbbbbb, 24'haaffff, 24'haaffcc, 24'haaff99, 24'haaff66, 24'haaff33,
    24'haaff00, 24'haadfff, 24'haadfcc, 24'haadf99, 24'haadf66, 24'haadf33, 24'haadf00,
    24'haabfff, 24'haabfcc, 24'haabf99, 24'haabf66, 24'haabf33, 24'haabf00, 24'haaaaaa,
    24'haa9fff, 24'haa9fcc, 24'haa9f99, 24'haa9f66, 24'haa9f33, 24'haa9f00, 24'haa7fff,
    24'haa7fcc, 24'haa7f99, 24'haa7f66, 24'haa7f33, 24'haa7f00, 24'haa5fff, 24'haa5fcc,
    24'haa5f99, 24'haa5f66, 24'haa5f33, 24'haa5f00, 24'haa3fff, 24'haa3fcc, 24'haa3f99,
    24'haa3f66, 24'haa3f33, 24'haa3f00, 24'haa1fff, 24'haa1fcc, 24'haa1f99, 24'haa1f66,
    24'haa1f33, 24'haa1f00, 24'haa00ff, 24'haa00cc, 24'haa0099, 24'haa0066, 24'haa0033,
    24'haa0000, 24'h999999, 24'h888888, 24'h777777, 24'h666666, 24'h55ffff, 24'h55ffcc,
    24'h55ff99, 24'h55ff66, 24'h55ff33, 24'h55ff00, 24'h55dfff, 24'h55dfcc, 24'h55df99,
    24'h55df66, 24'h55df33, 24'h55df00, 24'h55bfff, 24'h55bfcc, 24'h55bf99, 24'h55bf66,
    24'h55bf33, 24'h55bf00, 24'h559fff, 24'h559fcc, 24'h559f99, 24'h559f66, 24'h559f33,
    24'h559f00, 24'h557fff, 24'h557fcc, 24'h557f99, 24'h557f66, 24'h557f33, 24'h557f00,
    24'h555fff, 24'h555fcc, 24'h555f99, 24'h555f66, 24'h555f33, 24'h555f00, 24'h555555,
    24'h553fff, 24'h553fcc, 24'h553f99, 24'h553f66, 24'h553f33, 24'h553f00, 24'h551fff,
    24'h551fcc, 24'h551f99, 24'h551f66, 24'h551f33, 24'h551f00, 24'h5500ff, 24'h5500cc,
    24'h550099, 24'h550066, 24'h550033, 24'h550000, 24'h444444, 24'h333333, 24'h222222,
    24'h111111, 24'h00ffff, 24'h00ffcc, 24'h00ff99, 24'h00ff66, 24'h00ff33, 24'h00ff00,
    24'h00dfff, 24'h00dfcc, 24'h00df99, 24'h00df66, 24'h00df33, 24'h00df00, 24'h00bfff,
    24'h00bfcc, 24'h00bf99, 24'h00bf66, 24'h00bf33, 24'h00bf00, 24'h009fff, 24'h009fcc,
    24'h009f99, 24'h009f66, 24'h009f33, 24'h009f00, 24'h007fff, 24'h007fcc, 24'h007f99,
    24'h007f66, 24'h007f33, 24'h007f00, 24'h005fff, 24'h005fcc, 24'h005f99, 24'h005f66,
    24'h005f33, 24'h005f00, 24'h003fff, 24'h003fcc, 24'h003f99, 24'h003f66, 24'h003f33,
    24'h003f00, 24'h001fff, 24'h001fcc, 24'h001f99, 24'h001f66, 24'h001f33, 24'h001f00,
    24'h0000ff, 24'h0000cc, 24'h000099, 24'h000066, 24'h000033, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
    24'h000000, 24'h000000, 24'hf0f0f0, 24'he0e0e0, 24'hd0d0d0, 24'hc0c0c0, 24'hb0b0b0,
    24'ha0a0a0, 24'h808080, 24'h707070, 24'h606060, 24'h505050, 24'h404040, 24'h303030,
    24'h202020, 24'h101010, 24'h080808, 24'h000000
  };

  // A side of zero counts as one; a side above the maximum is clamped.
  function automatic logic [6:0] side_limit(input logic [6:0] v);
    logic [6:0] r;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if ({1'b0, v} > 8'(MaxSide)) begin
      r = 7'(MaxSide);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

@@ rtl/nrpd_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
module nrpd_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

@@ rtl/nibble_rle_palette_decoder.sv @@
// Run-length coded sprite decoder with a palette RAM lookup.
//
// Input channel: one coded byte per item (in_valid_i / in_stall_o). A byte
// with start_of_sprite set restarts the sprite and is taken as a count byte.
// Output channel: one pixel or error per item (out_valid_o / out_stall_i).
// Configuration: the user must write width, height and ghost mode through
// cfg_we_i, cfg_idx_i, cfg_wdata_i while the decoder is idle; it has no check.
//
// A literal byte's pixel passes through the run stage, where the palette RAM
// read completes, and then the output register; a new literal byte can be
// taken while the last one moves on. A count byte with N transparent pixels
// holds the run stage until the last of them moves on, and the next byte is
// taken then. Bytes that yield no pixel do not enter the run stage.
//
// After reset the palette RAM is loaded from its constant contents, one entry
// a cycle; in_stall_o stays high until all entries are loaded. The
// decoder starts idle and ignores bytes until a start of sprite. When the
// receiver stalls, the output register holds its item and the run stage and
// then the input back up behind it.
module nibble_rle_palette_decoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [6:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  nrpd_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output nrpd_pkg::out_item_t out_data_o
);

  import nrpd_pkg::*;

  `include "nibble_rle_palette_decoder_macros.svh"

  localparam int AddrW = $clog2(PalDepth);

  typedef enum logic [1:0] {
    KindLit,
    KindSkip,
    KindErr
  } kind_e;

  // Configuration registers.
  logic [6:0] width_q;
  logic [6:0] height_q;
  logic       ghost_q;

  // Decode state.
  logic [3:0] lit_pend_q, lit_pend_d;
  logic [6:0] cols_left_q, cols_left_d;
  logic [6:0] rows_done_q, rows_done_d;
  logic       fin_q, fin_d;

  // Palette load sweep.
  logic [AddrW:0] init_cnt_q;
  logic           init_busy;

  // Run stage between input and output register.
  logic       s1_valid_q;
  kind_e      s1_kind_q;
  logic [3:0] s1_cnt_q;
  logic       s1_done_q;
  logic [7:0] s1_alpha_q;

  logic       out_valid_q;
  out_item_t  out_q, out_d;

  // Decode of the current byte.
  logic       in_acc;
  logic       produce;
  kind_e      kind;
  logic [3:0] skip, lits;
  logic [6:0] width_eff, height_eff;
  logic       active;
  logic       row_end;
  logic       img_done;

  logic       adv;
  logic       s1_free;
  logic       s1_moves;
  logic       s1_stays;
  logic [PalWidth-1:0] pal_rdata;
  logic       pal_re;

  assign init_busy = ~init_cnt_q[AddrW];
  assign adv = ~out_valid_q | ~out_stall_i;
  assign s1_moves = s1_valid_q & adv;
  // A transparent run keeps the stage until its last pixel moves on.
  assign s1_stays = s1_moves & (s1_kind_q == KindSkip) & (s1_cnt_q != 4'd1);
  assign s1_free = ~s1_valid_q | (s1_moves & ~s1_stays);
  assign in_stall_o = init_busy | ~s1_free;
  assign in_acc = in_valid_i & ~in_stall_o;

  assign skip = in_data_i.data_byte[7:4];
  assign lits = in_data_i.data_byte[3:0];
  assign width_eff = side_limit(width_q);
  assign height_eff = side_limit(height_q);

  always_comb begin
    lit_pend_d = lit_pend_q;
    cols_left_d = cols_left_q;
    rows_done_d = rows_done_q;
    fin_d = fin_q;
    produce = 1'b0;
    kind = KindLit;
    row_end = 1'b0;
    img_done = 1'b0;
    active = 1'b1;
    if (in_data_i.start_of_sprite) begin
      rows_done_d = 7'd0;
      cols_left_d = width_eff;
      lit_pend_d = 4'd0;
      fin_d = 1'b0;
    end else if (fin_q) begin
      active = 1'b0;
    end
    if (active) begin
      if (lit_pend_d != 4'd0) begin
        lit_pend_d = lit_pend_d - 4'd1;
        produce = 1'b1;
        kind = KindLit;
        row_end = (lit_pend_d == 4'd0) && (cols_left_d == 7'd0);
      end else if ((7'(skip) + 7'(lits)) > cols_left_d) begin
        fin_d = 1'b1;
        lit_pend_d = 4'd0;
        produce = 1'b1;
        kind = KindErr;
      end else begin
        cols_left_d = cols_left_d - 7'(skip) - 7'(lits);
        lit_pend_d = lits;
        row_end = (lits == 4'd0) && (skip != 4'd0) && (cols_left_d == 7'd0);
        if (skip != 4'd0) begin
          produce = 1'b1;
          kind = KindSkip;
        end
      end
      if (row_end) begin
        rows_done_d = rows_done_d + 7'd1;
        if (rows_done_d >= height_eff) begin
          fin_d = 1'b1;
          img_done = 1'b1;
        end else begin
          cols_left_d = width_eff;
        end
      end
    end
  end

  assign pal_re = in_acc & produce & (kind == KindLit);

  nrpd_ram #(
    .Width(PalWidth),
    .Depth(PalDepth)
  ) u_palette (
    .clk_i  (clk_i),
    .we_i   (init_busy),
    .waddr_i(init_cnt_q[AddrW-1:0]),
    .wdata_i(PaletteRom[init_cnt_q[AddrW-1:0]]),
    .re_i   (pal_re),
    .raddr_i(in_data_i.data_byte),
    .rdata_o(pal_rdata)
  );

  always_comb begin
    out_d = '0;
    case (s1_kind_q)
      KindLit: begin
        out_d.pixel_valid = 1'b1;
        out_d.red = pal_rdata[7:0];
        out_d.green = pal_rdata[15:8];
        out_d.blue = pal_rdata[23:16];
        out_d.alpha = s1_alpha_q;
        out_d.last_of_run = 1'b1;
        out_d.image_done = s1_done_q;
      end
      KindSkip: begin
        out_d.pixel_valid = 1'b1;
        out_d.last_of_run = (s1_cnt_q == 4'd1);
        out_d.image_done = s1_done_q & (s1_cnt_q == 4'd1);
      end
      KindErr: begin
        out_d.last_of_run = 1'b1;
        out_d.overrun_error = 1'b1;
      end
      default: begin
        out_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
      height_q <= HeightReset;
      ghost_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgImageWidth: width_q <= cfg_wdata_i;
        CfgImageHeight: height_q <= cfg_wdata_i;
        CfgGhostMode: ghost_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_cnt_q <= '0;
      lit_pend_q <= 4'd0;
      cols_left_q <= 7'd0;
      rows_done_q <= 7'd0;
      fin_q <= 1'b1;
      s1_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (init_busy) begin
        init_cnt_q <= init_cnt_q + 1'b1;
      end
      if (in_acc) begin
        lit_pend_q <= lit_pend_d;
        cols_left_q <= cols_left_d;
        rows_done_q <= rows_done_d;
        fin_q <= fin_d;
      end
      if (in_acc && produce) begin
        s1_valid_q <= 1'b1;
      end else if (s1_moves && !s1_stays) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && produce) begin
      s1_kind_q <= kind;
      s1_cnt_q <= skip;
      s1_done_q <= img_done;
      s1_alpha_q <= ghost_q ? AlphaGhost : AlphaOpaque;
    end else if (s1_stays) begin
      s1_cnt_q <= s1_cnt_q - 4'd1;
    end
    if (s1_moves) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_q;

  `NRPD_ASSERT_IMP(a_skip_cnt_nonzero, s1_valid_q && (s1_kind_q == KindSkip), s1_cnt_q != 4'd0)
  `NRPD_ASSERT_IMP(a_err_stops_decode, s1_valid_q && (s1_kind_q == KindErr), fin_q)
  `NRPD_ASSERT_IMP(a_no_read_in_load, init_busy, !pal_re && !s1_valid_q)
  `NRPD_ASSERT_IMP(a_done_on_pixel, out_valid_q && out_q.image_done, out_q.pixel_valid && out_q.last_of_run)
  `NRPD_ASSERT_NXT(a_run_holds, s1_valid_q && (s1_kind_q == KindSkip) && !adv, s1_valid_q && $stable(s1_cnt_q))

endmodule
